/* design/itoa_pkg.sv */
package itoa_pkg;

	// Field widths of the two channels.
	localparam int VALUE_W = 32;
	localparam int RADIX_W = 6;
	localparam int WIDTH_W = 6;
	localparam int CHAR_W  = 7;

	// Character buffer: a run holds at most BUFFER_CHARS-1 characters.
	localparam int BUFFER_CHARS = 64;
	localparam int RUN_CAP      = BUFFER_CHARS - 1;
	localparam int IDX_W        = $clog2(BUFFER_CHARS);

	// Shared divider: DIV_BITS quotient bits per cycle.
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = VALUE_W / DIV_BITS;
	localparam int DSTEP_W   = $clog2(DIV_STEPS);
	localparam int REM_W     = RADIX_W + 1;

	localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_HEX  = RADIX_W'(16);
	localparam logic [RADIX_W-1:0] DIGIT_TEN  = RADIX_W'(10);

	localparam logic [CHAR_W-1:0] CHAR_ZERO       = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = CHAR_W'(8'h41 - 8'd10);
	localparam logic [CHAR_W-1:0] CHAR_MINUS      = CHAR_W'(8'h2D);
	localparam logic [CHAR_W-1:0] CHAR_SPACE      = CHAR_W'(8'h20);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] radix;
		logic               negative;
		logic [WIDTH_W-1:0] min_width;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              last;
	} out_item_t;

	// Microprogram.
	localparam int ROM_DEPTH = 8;
	localparam int PC_W      = $clog2(ROM_DEPTH);

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_PUSH_DIGIT,
		OP_PUSH_SIGN,
		OP_PUSH_FILL,
		OP_READ,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_IN,
		COND_DIV,
		COND_QUOT_NZ,
		COND_FILL,
		COND_EMIT
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctl_word_t;

	typedef struct packed {
		logic in_valid;
		logic div_done;
		logic quot_zero;
		logic fill_more;
		logic out_free;
		logic emit_last;
	} seq_status_t;

	localparam logic [PC_W-1:0] STEP_LOAD     = PC_W'(0);
	localparam logic [PC_W-1:0] STEP_DIV_INIT = PC_W'(1);
	localparam logic [PC_W-1:0] STEP_DIV      = PC_W'(2);
	localparam logic [PC_W-1:0] STEP_DIGIT    = PC_W'(3);
	localparam logic [PC_W-1:0] STEP_SIGN     = PC_W'(4);
	localparam logic [PC_W-1:0] STEP_FILL     = PC_W'(5);
	localparam logic [PC_W-1:0] STEP_READ     = PC_W'(6);
	localparam logic [PC_W-1:0] STEP_EMIT     = PC_W'(7);

	// Control store. A taken jump goes to target, and a step waiting on input or on a free
	// output holds; otherwise the step counter advances, and the last step wraps back to the load step.
	function automatic ctl_word_t ctl_rom(input logic [PC_W-1:0] pc);
		ctl_word_t w;
		unique case (pc)
			STEP_LOAD:     w = '{OP_LOAD,       COND_IN,      STEP_LOAD};
			STEP_DIV_INIT: w = '{OP_DIV_INIT,   COND_NONE,    STEP_LOAD};
			STEP_DIV:      w = '{OP_DIV_STEP,   COND_DIV,     STEP_DIV};
			STEP_DIGIT:    w = '{OP_PUSH_DIGIT, COND_QUOT_NZ, STEP_DIV_INIT};
			STEP_SIGN:     w = '{OP_PUSH_SIGN,  COND_NONE,    STEP_LOAD};
			STEP_FILL:     w = '{OP_PUSH_FILL,  COND_FILL,    STEP_FILL};
			STEP_READ:     w = '{OP_READ,       COND_NONE,    STEP_LOAD};
			STEP_EMIT:     w = '{OP_EMIT,       COND_EMIT,    STEP_READ};
			default:       w = '{OP_LOAD,       COND_IN,      STEP_LOAD};
		endcase
		return w;
	endfunction

endpackage

/* design/itoa_seq.sv */
module itoa_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  itoa_pkg::seq_status_t   status,
	output itoa_pkg::ctl_word_t     ctl
);
	import itoa_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_inc;
	logic [PC_W-1:0] pc_nxt;

	assign ctl    = ctl_rom(pc_q);
	assign pc_inc = pc_q + PC_W'(1);

	always_comb begin
		unique case (ctl.cond)
			COND_NONE:    pc_nxt = pc_inc;
			COND_IN:      pc_nxt = status.in_valid ? pc_inc : pc_q;
			COND_DIV:     pc_nxt = status.div_done ? pc_inc : ctl.target;
			COND_QUOT_NZ: pc_nxt = status.quot_zero ? pc_inc : ctl.target;
			COND_FILL:    pc_nxt = status.fill_more ? ctl.target : pc_inc;
			COND_EMIT: begin
				if (!status.out_free)
					pc_nxt = pc_q;
				else
					pc_nxt = status.emit_last ? pc_inc : ctl.target;
			end
			default:      pc_nxt = STEP_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= STEP_LOAD;
		else
			pc_q <= pc_nxt;
	end

endmodule

/* design/integer_to_ascii_formatter_core.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_data  (value, radix, negative, min_width)
// out     | output    | out_valid/out_ready| out_data (char_out, last)
//
// One item at a time. After the load step, for each digit the shared divider
// is set up and retires 4 quotient bits per cycle over the whole value, and
// the digit is written to the buffer. Then come the sign step, a fill step for
// each fill character plus a final check, and a read and an emit step per character.
// Reset clears the step counter and the output valid; a stall on the output
// holds the sequencer at its emit step while the output register waits.
module integer_to_ascii_formatter_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  itoa_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output itoa_pkg::out_item_t out_data
);
	import itoa_pkg::*;

	ctl_word_t   ctl;
	seq_status_t status;

	logic [VALUE_W-1:0] num_q;
	logic [RADIX_W-1:0] radix_q;
	logic               neg_q;
	logic [IDX_W-1:0]   width_q;
	logic [REM_W-1:0]   rem_q;
	logic [DSTEP_W-1:0] dstep_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [CHAR_W-1:0]  rd_q;
	logic [CHAR_W-1:0]  mem [BUFFER_CHARS];
	out_item_t          out_q;
	logic               out_valid_q;

	logic [VALUE_W-1:0] num_div;
	logic [REM_W-1:0]   rem_div;
	logic [RADIX_W-1:0] digit;
	logic [CHAR_W-1:0]  digit_char;
	logic [CHAR_W-1:0]  push_char;
	logic               push_en;
	logic [IDX_W:0]     width_in;
	logic               out_free;
	logic [IDX_W-1:0]   last_idx;

	itoa_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	assign in_ready  = (ctl.op == OP_LOAD);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;
	assign last_idx  = cnt_q - IDX_W'(1);

	assign status.in_valid  = in_valid;
	assign status.div_done  = (dstep_q == DSTEP_W'(DIV_STEPS - 1));
	assign status.quot_zero = (num_q == '0);
	assign status.fill_more = (cnt_q < width_q);
	assign status.out_free  = out_free;
	assign status.emit_last = (cnt_q == IDX_W'(1));

	// Restoring division, DIV_BITS bits per cycle; the quotient shifts into num.
	always_comb begin
		rem_div = rem_q;
		num_div = num_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			rem_div = {rem_div[REM_W-2:0], num_div[VALUE_W-1]};
			num_div = {num_div[VALUE_W-2:0], 1'b0};
			if (rem_div >= {1'b0, radix_q}) begin
				rem_div    = rem_div - {1'b0, radix_q};
				num_div[0] = 1'b1;
			end
		end
	end

	assign digit      = rem_q[RADIX_W-1:0];
	assign digit_char = (digit < DIGIT_TEN) ? CHAR_ZERO + CHAR_W'(digit)
	                                        : CHAR_ALPHA_BASE + CHAR_W'(digit);

	assign width_in = {1'b0, in_data.min_width};

	always_comb begin
		push_en   = 1'b0;
		push_char = digit_char;
		unique case (ctl.op)
			OP_PUSH_DIGIT: push_en = 1'b1;
			OP_PUSH_SIGN: begin
				push_en   = neg_q;
				push_char = CHAR_MINUS;
			end
			OP_PUSH_FILL: begin
				push_en   = status.fill_more;
				push_char = (radix_q == RADIX_HEX) ? CHAR_ZERO : CHAR_SPACE;
			end
			default: push_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_en)
			mem[cnt_q] <= push_char;
		if (ctl.op == OP_READ)
			rd_q <= mem[last_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			dstep_q <= '0;
		end else begin
			if (ctl.op == OP_LOAD && in_valid)
				cnt_q <= '0;
			else if (push_en)
				cnt_q <= cnt_q + IDX_W'(1);
			else if (ctl.op == OP_EMIT && out_free)
				cnt_q <= last_idx;

			if (ctl.op == OP_DIV_INIT)
				dstep_q <= '0;
			else if (ctl.op == OP_DIV_STEP)
				dstep_q <= dstep_q + DSTEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				if (in_valid) begin
					num_q   <= in_data.value;
					radix_q <= (in_data.radix < RADIX_MIN) ? RADIX_MIN : in_data.radix;
					neg_q   <= in_data.negative;
					width_q <= (width_in > (IDX_W + 1)'(RUN_CAP)) ? IDX_W'(RUN_CAP)
					                                              : IDX_W'(in_data.min_width);
				end
			end
			OP_DIV_INIT: rem_q <= '0;
			OP_DIV_STEP: begin
				rem_q <= rem_div;
				num_q <= num_div;
			end
			default: ;
		endcase
	end

	// Output register: it takes a character when it is empty or as the previous one transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_EMIT && out_free) begin
			out_q.char_out <= rd_q;
			out_q.last     <= status.emit_last;
		end
	end

`ifndef SYNTHESIS
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_EMIT) |-> (cnt_q != '0))
		else $error("emit step reached with an empty buffer");

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_PUSH_DIGIT) |-> (rem_q < {1'b0, radix_q}))
		else $error("digit not below radix");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (cnt_q == '0 && ctl.op == OP_DIV_INIT))
		else $error("accepted item did not start a fresh run");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_EMIT && out_free && status.emit_last) |=> (ctl.op == OP_LOAD))
		else $error("sequencer did not return to load after the final character");
`endif

endmodule
